// ----- hw/rtl/ksel_pkg.sv -----
// ----------------------------------------------------------------------------
// ksel_pkg
// Shared types, widths and codes of the k-th smallest select block.
// ----------------------------------------------------------------------------
`default_nettype none

package ksel_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int VALUE_BITS   = 32;
  localparam int TAG_BITS     = 16;
  localparam int ADDR_BITS    = $clog2(MAX_ELEMENTS);
  // signed element index, one bit of headroom on each side
  localparam int IDX_BITS     = ADDR_BITS + 2;
  localparam int WORD_BITS    = VALUE_BITS + TAG_BITS;

  localparam int COUNT_BITS   = 13;
  localparam int FRAC_BITS    = 10;
  localparam int RANK_BITS    = 12;
  localparam int STATUS_BITS  = 3;
  localparam int PROD_BITS    = FRAC_BITS + COUNT_BITS;
  localparam int DIVISOR      = 1000;
  // scaled reciprocal of the divisor, exact for every product below 2**23
  localparam int RECIP_SHIFT  = 33;
  localparam int RECIP_BITS   = 24;
  localparam logic [RECIP_BITS-1:0] DIV_RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam int COUNT_RESET  = 4096;

  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_BITS-1:0] STAT_LOAD_OK    = STATUS_BITS'(0);
  localparam logic [STATUS_BITS-1:0] STAT_QUERY_OK   = STATUS_BITS'(1);
  localparam logic [STATUS_BITS-1:0] STAT_INCOMPLETE = STATUS_BITS'(2);
  localparam logic [STATUS_BITS-1:0] STAT_ZERO_RANK  = STATUS_BITS'(3);
  localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW   = STATUS_BITS'(4);

  typedef struct packed {
    logic                  operation;
    logic                  first;
    logic [VALUE_BITS-1:0] distance;
    logic [TAG_BITS-1:0]   tag;
    logic [FRAC_BITS-1:0]  fraction_permille;
  } ksel_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  selected_value;
    logic [TAG_BITS-1:0]    selected_tag;
    logic [RANK_BITS-1:0]   rank_used;
    logic [STATUS_BITS-1:0] status;
  } ksel_res_t;

  // one store entry: tag and value move together
  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [VALUE_BITS-1:0] value;
  } ksel_word_t;

  typedef struct packed {
    logic                 done;
    logic [PROD_BITS-1:0] quot;
  } ksel_div_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_TOP, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_STEP,
    S_PIV_RD, S_PIV_CAP, S_SCAN_I, S_SCAN_I_CHK, S_SCAN_J, S_SCAN_J_CHK,
    S_TEST, S_FIN_RD, S_FIN_WLO, S_FIN_WJ, S_OUT_RD, S_OUT
  } ksel_state_t;

  typedef enum logic [2:0] {
    PH_PAIR, PH_MID, PH_C1, PH_C2, PH_C3, PH_SCAN
  } ksel_phase_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ksel_ram.sv -----
// ----------------------------------------------------------------------------
// ksel_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ksel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ksel_div.sv -----
// ----------------------------------------------------------------------------
// ksel_div
// Division by the fixed permille divisor through a scaled reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module ksel_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ksel_pkg::PROD_BITS-1:0] product,
  output ksel_pkg::ksel_div_t                 stat
);

  localparam int SB = ksel_pkg::PROD_BITS + ksel_pkg::RECIP_BITS;

  logic [1:0]                     stage;
  logic [ksel_pkg::PROD_BITS-1:0] prod;
  logic [ksel_pkg::PROD_BITS-1:0] quot;
  logic [SB-1:0]                  scaled;

  // product times the scaled reciprocal
  always_comb begin
    scaled = SB'(prod) * SB'(ksel_pkg::DIV_RECIP);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[0], start};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= product;
    end
    if (stage[0]) begin
      quot <= ksel_pkg::PROD_BITS'(scaled >> ksel_pkg::RECIP_SHIFT);
    end
  end

  assign stat.done = stage[1];
  assign stat.quot = quot;

endmodule

`default_nettype wire

// ----- hw/rtl/kth_smallest_select_with_tag_core.sv -----
// ----------------------------------------------------------------------------
// kth_smallest_select_with_tag_core
// Loads tagged distances into a store and answers k-th smallest queries by
// in-place quickselect with median-of-three pivots over one store RAM.
// ----------------------------------------------------------------------------
// Loads, incomplete-set queries: result strobe in the cycle after acceptance,
//   next request taken in the cycle after acceptance, as the block stays idle.
// Good queries: rank division first, then quickselect on the RAM with at most
//   one access per cycle; a scan step reads one word and compares it with the
//   pivot, a swap reads two words and writes both back when they must change.
// Zero-rank queries end when the rank division is done. No stall from the
//   receiver. Synchronous reset clears fill level and control and sets the
//   count register to COUNT_RESET; the store is not cleared.
`default_nettype none

module kth_smallest_select_with_tag_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire ksel_pkg::ksel_req_t             req,
  output logic                                 res_valid,
  output ksel_pkg::ksel_res_t                  res,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ksel_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [ksel_pkg::PDATA_BITS-1:0] pwdata,
  output logic      [ksel_pkg::PDATA_BITS-1:0] prdata,
  output logic                                 pready
);

  localparam int AB = ksel_pkg::ADDR_BITS;
  localparam int IB = ksel_pkg::IDX_BITS;
  localparam int CB = ksel_pkg::COUNT_BITS;

  ksel_pkg::ksel_state_t state, state_next;
  ksel_pkg::ksel_phase_t phase;

  logic [CB-1:0] element_count;
  logic [CB-1:0] fill_level;
  logic [CB-1:0] count_eff;
  logic [CB-1:0] fl_base;
  logic          load_ok;
  logic          accept;
  logic          query_go;

  logic signed [IB-1:0] lo, hi, i_idx, j_idx, k_idx;
  logic signed [IB-1:0] mid, lo_p1, ni, nj;
  logic [AB-1:0]        sw_a, sw_b;
  logic                 sw_always;
  logic                 sw_do;
  ksel_pkg::ksel_word_t va, pivot, rword;

  logic                            we;
  logic [AB-1:0]                   waddr, raddr;
  logic [ksel_pkg::WORD_BITS-1:0]  wdata, rdata;

  ksel_pkg::ksel_div_t div_stat;
  logic [CB-1:0]       nb;

  logic                res_fire;
  ksel_pkg::ksel_res_t res_data;

  // store of tagged values
  ksel_ram #(
    .WIDTH(ksel_pkg::WORD_BITS),
    .DEPTH(ksel_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // rank = floor(fraction * count / 1000), capped at count
  ksel_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (query_go),
    .product(ksel_pkg::PROD_BITS'(req.fraction_permille) * ksel_pkg::PROD_BITS'(count_eff)),
    .stat   (div_stat)
  );

  // handshake and common terms
  always_comb begin
    busy      = state != ksel_pkg::S_IDLE;
    accept    = start && !busy;
    count_eff = (element_count > CB'(ksel_pkg::MAX_ELEMENTS)) ? CB'(ksel_pkg::MAX_ELEMENTS)
                                                              : element_count;
    fl_base   = req.first ? '0 : fill_level;
    load_ok   = fl_base < count_eff;
    query_go  = accept && (req.operation == ksel_pkg::OP_QUERY) && (fill_level >= count_eff);
    mid       = (lo + hi) >>> 1;
    lo_p1     = lo + IB'(1);
    ni        = i_idx + IB'(1);
    nj        = j_idx - IB'(1);
    rword     = ksel_pkg::ksel_word_t'(rdata);
    sw_do     = sw_always || (va.value > rword.value);
    nb        = (div_stat.quot > ksel_pkg::PROD_BITS'(count_eff)) ? count_eff
                                                                  : div_stat.quot[CB-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ksel_pkg::S_IDLE:       if (query_go) state_next = ksel_pkg::S_DIV;
      ksel_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_next = (nb == '0) ? ksel_pkg::S_IDLE : ksel_pkg::S_TOP;
        end
      end
      ksel_pkg::S_TOP: begin
        if (hi <= lo_p1) begin
          state_next = (hi == lo_p1) ? ksel_pkg::S_SW_RA : ksel_pkg::S_OUT_RD;
        end else begin
          state_next = ksel_pkg::S_SW_RA;
        end
      end
      ksel_pkg::S_SW_RA:      state_next = ksel_pkg::S_SW_RB;
      ksel_pkg::S_SW_RB:      state_next = ksel_pkg::S_SW_WA;
      ksel_pkg::S_SW_WA:      state_next = sw_do ? ksel_pkg::S_SW_WB : ksel_pkg::S_STEP;
      ksel_pkg::S_SW_WB:      state_next = ksel_pkg::S_STEP;
      ksel_pkg::S_STEP: begin
        unique case (phase)
          ksel_pkg::PH_PAIR: state_next = ksel_pkg::S_OUT_RD;
          ksel_pkg::PH_C3:   state_next = ksel_pkg::S_PIV_RD;
          ksel_pkg::PH_SCAN: state_next = ksel_pkg::S_SCAN_I;
          default:           state_next = ksel_pkg::S_SW_RA;
        endcase
      end
      ksel_pkg::S_PIV_RD:     state_next = ksel_pkg::S_PIV_CAP;
      ksel_pkg::S_PIV_CAP:    state_next = ksel_pkg::S_SCAN_I;
      ksel_pkg::S_SCAN_I:     state_next = (ni < hi) ? ksel_pkg::S_SCAN_I_CHK : ksel_pkg::S_SCAN_J;
      ksel_pkg::S_SCAN_I_CHK: begin
        state_next = (rword.value < pivot.value) ? ksel_pkg::S_SCAN_I : ksel_pkg::S_SCAN_J;
      end
      ksel_pkg::S_SCAN_J:     state_next = (nj > lo) ? ksel_pkg::S_SCAN_J_CHK : ksel_pkg::S_TEST;
      ksel_pkg::S_SCAN_J_CHK: begin
        state_next = (rword.value > pivot.value) ? ksel_pkg::S_SCAN_J : ksel_pkg::S_TEST;
      end
      ksel_pkg::S_TEST:       state_next = (j_idx < i_idx) ? ksel_pkg::S_FIN_RD : ksel_pkg::S_SW_RA;
      ksel_pkg::S_FIN_RD:     state_next = ksel_pkg::S_FIN_WLO;
      ksel_pkg::S_FIN_WLO:    state_next = ksel_pkg::S_FIN_WJ;
      ksel_pkg::S_FIN_WJ:     state_next = ksel_pkg::S_TOP;
      ksel_pkg::S_OUT_RD:     state_next = ksel_pkg::S_OUT;
      ksel_pkg::S_OUT:        state_next = ksel_pkg::S_IDLE;
      default:                state_next = ksel_pkg::S_IDLE;
    endcase
  end

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      ksel_pkg::S_IDLE: begin
        if (accept && (req.operation == ksel_pkg::OP_LOAD) && load_ok) begin
          we    = 1'b1;
          waddr = fl_base[AB-1:0];
          wdata = {req.tag, req.distance};
        end
      end
      ksel_pkg::S_SW_RA:  raddr = sw_a;
      ksel_pkg::S_SW_RB:  raddr = sw_b;
      ksel_pkg::S_SW_WA: begin
        if (sw_do) begin
          we    = 1'b1;
          waddr = sw_a;
          wdata = rword;
        end
      end
      ksel_pkg::S_SW_WB: begin
        we    = 1'b1;
        waddr = sw_b;
        wdata = va;
      end
      ksel_pkg::S_PIV_RD: raddr = lo[AB-1:0];
      ksel_pkg::S_SCAN_I: raddr = ni[AB-1:0];
      ksel_pkg::S_SCAN_J: raddr = nj[AB-1:0];
      ksel_pkg::S_FIN_RD: raddr = j_idx[AB-1:0];
      ksel_pkg::S_FIN_WLO: begin
        we    = 1'b1;
        waddr = lo[AB-1:0];
        wdata = rword;
      end
      ksel_pkg::S_FIN_WJ: begin
        we    = 1'b1;
        waddr = j_idx[AB-1:0];
        wdata = pivot;
      end
      ksel_pkg::S_OUT_RD: raddr = k_idx[AB-1:0];
      default: ;
    endcase
  end

  // result formation
  always_comb begin
    res_fire = 1'b0;
    res_data = '0;
    unique case (state)
      ksel_pkg::S_IDLE: begin
        if (accept) begin
          if (req.operation == ksel_pkg::OP_LOAD) begin
            res_fire        = 1'b1;
            res_data.status = load_ok ? ksel_pkg::STAT_LOAD_OK : ksel_pkg::STAT_OVERFLOW;
          end else if (!query_go) begin
            res_fire        = 1'b1;
            res_data.status = ksel_pkg::STAT_INCOMPLETE;
          end
        end
      end
      ksel_pkg::S_DIV: begin
        if (div_stat.done && (nb == '0)) begin
          res_fire        = 1'b1;
          res_data.status = ksel_pkg::STAT_ZERO_RANK;
        end
      end
      ksel_pkg::S_OUT: begin
        res_fire                = 1'b1;
        res_data.selected_value = rword.value;
        res_data.selected_tag   = rword.tag;
        res_data.rank_used      = k_idx[ksel_pkg::RANK_BITS-1:0];
        res_data.status         = ksel_pkg::STAT_QUERY_OK;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ksel_pkg::S_IDLE;
      fill_level    <= '0;
      element_count <= CB'(ksel_pkg::COUNT_RESET);
      res_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_fire;
      if (psel && penable && pwrite && (paddr[ksel_pkg::PADDR_BITS-1] ==
          ksel_pkg::REG_ELEMENT_COUNT)) begin
        element_count <= pwdata[CB-1:0];
      end
      if (accept && (req.operation == ksel_pkg::OP_LOAD)) begin
        fill_level <= load_ok ? fl_base + CB'(1) : fl_base;
      end
    end
  end

  // quickselect bounds, swap operands and result
  always_ff @(posedge clk) begin
    if (res_fire) begin
      res <= res_data;
    end
    unique case (state)
      ksel_pkg::S_DIV: begin
        if (div_stat.done) begin
          k_idx <= IB'(nb) - IB'(1);
          lo    <= '0;
          hi    <= IB'(count_eff) - IB'(1);
        end
      end
      ksel_pkg::S_TOP: begin
        if (hi <= lo_p1) begin
          sw_a      <= lo[AB-1:0];
          sw_b      <= hi[AB-1:0];
          sw_always <= 1'b0;
          phase     <= ksel_pkg::PH_PAIR;
        end else begin
          sw_a      <= mid[AB-1:0];
          sw_b      <= lo_p1[AB-1:0];
          sw_always <= 1'b1;
          phase     <= ksel_pkg::PH_MID;
        end
      end
      ksel_pkg::S_SW_RB: va <= rword;
      // median-of-three ordering of lo, lo+1 and hi
      ksel_pkg::S_STEP: begin
        sw_always <= 1'b0;
        unique case (phase)
          ksel_pkg::PH_MID: begin
            sw_a  <= lo_p1[AB-1:0];
            sw_b  <= hi[AB-1:0];
            phase <= ksel_pkg::PH_C1;
          end
          ksel_pkg::PH_C1: begin
            sw_a  <= lo[AB-1:0];
            sw_b  <= hi[AB-1:0];
            phase <= ksel_pkg::PH_C2;
          end
          ksel_pkg::PH_C2: begin
            sw_a  <= lo_p1[AB-1:0];
            sw_b  <= lo[AB-1:0];
            phase <= ksel_pkg::PH_C3;
          end
          default: ;
        endcase
      end
      ksel_pkg::S_PIV_CAP: begin
        pivot <= rword;
        i_idx <= lo_p1;
        j_idx <= hi;
      end
      ksel_pkg::S_SCAN_I: i_idx <= ni;
      ksel_pkg::S_SCAN_J: j_idx <= nj;
      ksel_pkg::S_TEST: begin
        if (!(j_idx < i_idx)) begin
          sw_a      <= i_idx[AB-1:0];
          sw_b      <= j_idx[AB-1:0];
          sw_always <= 1'b1;
          phase     <= ksel_pkg::PH_SCAN;
        end
      end
      // narrow the range around the rank
      ksel_pkg::S_FIN_WJ: begin
        if (j_idx >= k_idx) hi <= nj;
        if (j_idx <= k_idx) lo <= i_idx;
      end
      default: ;
    endcase
  end

  // register read-back
  assign prdata = (paddr[ksel_pkg::PADDR_BITS-1] == ksel_pkg::REG_ELEMENT_COUNT)
                  ? ksel_pkg::PDATA_BITS'(element_count) : '0;
  assign pready = 1'b1;

endmodule

`default_nettype wire

// ----- hw/rtl/ksel_checker.sv -----
// ----------------------------------------------------------------------------
// ksel_props
// Port-level checks of the k-th smallest select block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ksel_props (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire ksel_pkg::ksel_req_t req,
  input wire logic                res_valid,
  input wire ksel_pkg::ksel_res_t res,
  input wire logic                pready
);

  // a load request answers in the next cycle and leaves the block free
  a_load_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.operation == ksel_pkg::OP_LOAD) |=> res_valid && !busy)
    else $error("load request not answered in the next cycle");

  // a query request is either answered at once or occupies the block
  a_query_taken: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.operation == ksel_pkg::OP_QUERY) |=> res_valid || busy)
    else $error("query request lost");

  // the block only goes free together with a result
  a_free_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> res_valid)
    else $error("busy dropped without a result");

  // results other than a good query carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != ksel_pkg::STAT_QUERY_OK) |->
      (res.selected_value == '0) && (res.selected_tag == '0) && (res.rank_used == '0))
    else $error("nonzero payload on a non-query result");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind kth_smallest_select_with_tag_core ksel_props u_ksel_props (.*);

`default_nettype wire
